[rtl/core/tsc_monotonic_clock_and_wakeup_assert.svh]
// Assertion macros for the monotonic clock block.
// Included by tsc_ctrl, which checks its own control logic; no other dependencies.
`ifndef TSC_MONOTONIC_CLOCK_AND_WAKEUP_ASSERT_SVH
`define TSC_MONOTONIC_CLOCK_AND_WAKEUP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("tsc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("tsc assertion failed");

`endif

[rtl/core/tsc_pkg.sv]
// Shared codes, reset values and controller/datapath interface types.
// No dependencies.
`default_nettype none
package tsc_pkg;

	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_WAKE  = 2'd2;

	localparam logic [1:0] ST_TIME   = 2'd0;
	localparam logic [1:0] ST_PASSED = 2'd1;
	localparam logic [1:0] ST_SHORT  = 2'd2;
	localparam logic [1:0] ST_PROG   = 2'd3;

	localparam logic [31:0] C2NS_MULT_RST = 32'd2147483648;
	localparam logic [31:0] NS2TICK_MULT_RST = 32'd5124677;
	localparam logic [15:0] MIN_WAKE_RST = 16'd16;

	localparam int MAX_TIMER_TICKS_DEF = 65535;

	typedef struct packed {
		logic load_in;   // capture input word and form the scaler operand
		logic start;     // item is a base load, not a delta
		logic mul_lo;    // multiply low operand half
		logic mul_hi;    // multiply high operand half
		logic sum;       // fold high partial product into accumulator
		logic tick_mult; // use the ns-to-tick multiplier
		logic upd;       // commit new time and counter sample
		logic cmp;       // compare deadline, form remaining ns
		logic tick;      // classify tick count
		logic load_out;  // move result into output register
	} tsc_cmd_t;

	typedef struct packed {
		logic passed;
	} tsc_sts_t;

endpackage
`default_nettype wire

[rtl/core/tsc_ctrl.sv]
// Sequencer for the monotonic clock: drives the shared scaler passes and output word.
// Depends on tsc_pkg and the assertion macro header.
`default_nettype none
`include "tsc_monotonic_clock_and_wakeup_assert.svh"
module tsc_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       mode,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire tsc_pkg::tsc_sts_t sts,
	output tsc_pkg::tsc_cmd_t     cmd
);
	import tsc_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MLO  = 3'd1;
	localparam logic [2:0] S_MHI  = 3'd2;
	localparam logic [2:0] S_SUM  = 3'd3;
	localparam logic [2:0] S_UPD  = 3'd4;
	localparam logic [2:0] S_CMP  = 3'd5;
	localparam logic [2:0] S_TICK = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	logic [2:0] state_q;
	logic [1:0] mode_q;
	logic       phase_q;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.load_in   = accept;
		cmd.start     = (state_q == S_IDLE) ? (mode == MODE_START) : (mode_q == MODE_START);
		cmd.mul_lo    = (state_q == S_MLO);
		cmd.mul_hi    = (state_q == S_MHI);
		cmd.sum       = (state_q == S_SUM);
		cmd.tick_mult = phase_q;
		cmd.upd       = (state_q == S_UPD);
		cmd.cmp       = (state_q == S_CMP);
		cmd.tick      = (state_q == S_TICK);
		cmd.load_out  = (state_q == S_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_START;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q  <= mode;
						phase_q <= 1'b0;
						state_q <= S_MLO;
					end
				end
				S_MLO: state_q <= S_MHI;
				S_MHI: state_q <= S_SUM;
				S_SUM: state_q <= phase_q ? S_TICK : S_UPD;
				S_UPD: state_q <= (mode_q == MODE_WAKE) ? S_CMP : S_OUT;
				S_CMP: begin
					if (sts.passed) begin
						state_q <= S_OUT;
					end else begin
						phase_q <= 1'b1;
						state_q <= S_MLO;
					end
				end
				S_TICK: state_q <= S_OUT;
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`TSC_ASSERT_NEXT(a_accept_starts_scaler, clk, arst_n, accept, state_q == S_MLO)
	`TSC_ASSERT_NOW(a_no_result_overwrite, clk, arst_n, cmd.load_out, out_free)
	`TSC_ASSERT_NOW(a_tick_pass_only_wake, clk, arst_n, state_q == S_TICK, (mode_q == MODE_WAKE) && phase_q)

endmodule
`default_nettype wire

[rtl/core/tsc_dpath.sv]
// Datapath: time/counter state, shared 32x32 scaler with accumulator, wake logic, output word.
// Depends on tsc_pkg; driven by tsc_ctrl commands.
`default_nettype none
module tsc_dpath #(
	parameter int MAX_TIMER_TICKS = tsc_pkg::MAX_TIMER_TICKS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tsc_pkg::tsc_cmd_t cmd,
	output tsc_pkg::tsc_sts_t      sts,
	input  wire logic [63:0]       cycle_count,
	input  wire logic [63:0]       deadline_ns,
	input  wire logic [31:0]       cycle_to_ns_mult,
	input  wire logic [31:0]       ns_to_tick_mult,
	input  wire logic [15:0]       min_wake_ticks,
	output logic [63:0]            now_ns,
	output logic [1:0]             status,
	output logic [15:0]            reload_value
);
	import tsc_pkg::*;

	localparam logic [15:0] MAX_TICKS = 16'(MAX_TIMER_TICKS);

	logic [63:0] last_q, elapsed_q;
	logic [63:0] count_q, deadline_q;
	logic [63:0] op_q, prod_q, acc_q;
	logic [1:0]  res_status_q;
	logic [15:0] res_reload_q;
	logic [63:0] now_ns_q;
	logic [1:0]  status_q;
	logic [15:0] reload_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_d;
	logic [15:0] clamped;

	assign mul_a  = cmd.mul_hi ? op_q[63:32] : op_q[31:0];
	assign mul_b  = cmd.tick_mult ? ns_to_tick_mult : cycle_to_ns_mult;
	assign prod_d = 64'(mul_a) * 64'(mul_b);

	assign sts.passed = (deadline_q < elapsed_q);
	assign clamped    = (acc_q > {48'd0, MAX_TICKS}) ? MAX_TICKS : acc_q[15:0];

	// Architectural state, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= '0;
			elapsed_q <= '0;
		end else if (cmd.upd) begin
			elapsed_q <= (cmd.start ? 64'd0 : elapsed_q) + acc_q;
			last_q    <= count_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			count_q    <= cycle_count;
			deadline_q <= deadline_ns;
			op_q       <= cmd.start ? cycle_count : cycle_count - last_q;
		end else if (cmd.cmp) begin
			op_q <= deadline_q - elapsed_q;
		end
		if (cmd.mul_lo || cmd.mul_hi)
			prod_q <= prod_d;
		if (cmd.mul_hi)
			acc_q <= {32'd0, prod_q[63:32]};
		else if (cmd.sum)
			acc_q <= acc_q + prod_q;
		if (cmd.upd) begin
			res_status_q <= ST_TIME;
			res_reload_q <= '0;
		end else if (cmd.cmp && sts.passed) begin
			res_status_q <= ST_PASSED;
		end else if (cmd.tick) begin
			if (acc_q < {48'd0, min_wake_ticks}) begin
				res_status_q <= ST_SHORT;
			end else begin
				res_status_q <= ST_PROG;
				res_reload_q <= (clamped == 16'd0) ? 16'd0 : clamped - 16'd1;
			end
		end
		if (cmd.load_out) begin
			now_ns_q <= elapsed_q;
			status_q <= res_status_q;
			reload_q <= res_reload_q;
		end
	end

	assign now_ns       = now_ns_q;
	assign status       = status_q;
	assign reload_value = reload_q;

endmodule
`default_nettype wire

[rtl/core/tsc_monotonic_clock_and_wakeup.sv]
// Top level of the monotonic nanosecond clock and wake-timer calculator.
// Depends on tsc_pkg, tsc_ctrl and tsc_dpath; holds the APB register file.
`default_nettype none
// Usage:
// - Input channel (in_valid/in_ready) takes one word: mode, cycle_count, deadline_ns.
//   mode 0 loads the time base from the counter, mode 1 (and 3) advances the clock by
//   the scaled counter delta, mode 2 advances it and computes a wake-timer reload.
// - Output channel (out_valid/out_ready) returns one word per input word: now_ns,
//   status and reload_value (reload_value is zero unless status is "timer programmed").
// - One item is in work at a time; the next item is taken after the result has moved
//   into the output register. The single 32x32 multiplier makes two passes (low half,
//   high half) plus a fold per 64-bit scaling; start and read need one scaling, a wake
//   whose deadline is still ahead needs two, and one whose deadline has passed needs one.
// - in_ready is high only while the sequencer is idle; it does not depend on out_ready.
//   A finished word sits in the output register while the next item is accepted.
//   If the receiver stalls, the sequencer holds the next result until the output
//   register frees up, then continues.
// - Reset (arst_n low) clears the time and last counter sample to zero, restores the
//   register defaults and drops any pending output word.
// - Registers (APB, pready always high): 0x0 cycle_to_ns_mult, 0x4 ns_to_tick_mult,
//   0x8 min_wake_ticks. Write them only while the block is idle.
module tsc_monotonic_clock_and_wakeup #(
	parameter int MAX_TIMER_TICKS = tsc_pkg::MAX_TIMER_TICKS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [63:0] cycle_count,
	input  wire logic [63:0] deadline_ns,
	// output channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      now_ns,
	output logic [1:0]       status,
	output logic [15:0]      reload_value
);
	import tsc_pkg::*;

	localparam logic [1:0] REG_C2NS    = 2'd0;
	localparam logic [1:0] REG_NS2TICK = 2'd1;
	localparam logic [1:0] REG_MINWAKE = 2'd2;

	logic [31:0] c2ns_q;
	logic [31:0] ns2tick_q;
	logic [15:0] min_wake_q;
	logic        cfg_wr;

	tsc_cmd_t cmd;
	tsc_sts_t sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Register writes land on the access cycle; unused addresses are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c2ns_q     <= C2NS_MULT_RST;
			ns2tick_q  <= NS2TICK_MULT_RST;
			min_wake_q <= MIN_WAKE_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_C2NS:    c2ns_q     <= pwdata;
				REG_NS2TICK: ns2tick_q  <= pwdata;
				REG_MINWAKE: min_wake_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_C2NS:    prdata = c2ns_q;
			REG_NS2TICK: prdata = ns2tick_q;
			REG_MINWAKE: prdata = {16'd0, min_wake_q};
			default:     prdata = '0;
		endcase
	end

	tsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tsc_dpath #(
		.MAX_TIMER_TICKS (MAX_TIMER_TICKS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cycle_count      (cycle_count),
		.deadline_ns      (deadline_ns),
		.cycle_to_ns_mult (c2ns_q),
		.ns_to_tick_mult  (ns2tick_q),
		.min_wake_ticks   (min_wake_q),
		.now_ns           (now_ns),
		.status           (status),
		.reload_value     (reload_value)
	);

endmodule
`default_nettype wire

[test/tsc_clock_monitor.sv]
// Channel monitor for the monotonic clock block: tracks register writes, predicts every result
// word from the accepted input words and compares it field by field. Depends on tsc_pkg.
`timescale 1ns / 100ps

package tsc_tb_pkg;
	localparam logic [3:0] ADDR_C2NS_MULT    = 4'h0;
	localparam logic [3:0] ADDR_NS2TICK_MULT = 4'h4;
	localparam logic [3:0] ADDR_MIN_WAKE     = 4'h8;
endpackage

module tsc_clock_monitor #(
	parameter int MAX_TIMER_TICKS = tsc_pkg::MAX_TIMER_TICKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [63:0] cycle_count,
	input  logic [63:0] deadline_ns,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] now_ns,
	input  logic [1:0]  status,
	input  logic [15:0] reload_value,
	output int          mismatches,
	output int          open_words
);
	import tsc_pkg::*;
	import tsc_tb_pkg::*;

	localparam logic [63:0] TICK_CAP = 64'(MAX_TIMER_TICKS);

	typedef struct packed {
		logic [63:0] now;
		logic [1:0]  status;
		logic [15:0] reload;
	} clock_word_t;

	logic [31:0] c2ns_mult;
	logic [31:0] ns2tick_mult;
	logic [15:0] min_wake;
	logic [63:0] last_count;
	logic [63:0] time_ns;
	clock_word_t due_words[$];

	// (a * m) >> 32 on a 64x32 product, low 64 bits kept
	function automatic logic [63:0] fx_scale(input logic [63:0] a, input logic [31:0] m);
		logic [95:0] prod;
		prod = {32'd0, a} * {64'd0, m};
		return prod[95:32];
	endfunction

	function clock_word_t advance_clock(input logic [1:0] m, input logic [63:0] cnt,
			input logic [63:0] dl);
		clock_word_t w;
		logic [63:0] ticks;
		if (m == MODE_START) begin
			time_ns = fx_scale(cnt, c2ns_mult);
		end else begin
			time_ns = time_ns + fx_scale(cnt - last_count, c2ns_mult);
		end
		last_count = cnt;
		w.now = time_ns;
		w.status = ST_TIME;
		w.reload = '0;
		if (m == MODE_WAKE) begin
			if (dl < time_ns) begin
				w.status = ST_PASSED;
			end else begin
				ticks = fx_scale(dl - time_ns, ns2tick_mult);
				if (ticks < 64'(min_wake)) begin
					w.status = ST_SHORT;
				end else begin
					if (ticks > TICK_CAP) ticks = TICK_CAP;
					w.status = ST_PROG;
					w.reload = (ticks != 0) ? 16'(ticks - 1) : 16'd0;
				end
			end
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		clock_word_t want;
		if (!arst_n) begin
			c2ns_mult = C2NS_MULT_RST;
			ns2tick_mult = NS2TICK_MULT_RST;
			min_wake = MIN_WAKE_RST;
			last_count = '0;
			time_ns = '0;
			due_words.delete();
			mismatches = 0;
			open_words = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ADDR_C2NS_MULT:    c2ns_mult = pwdata;
					ADDR_NS2TICK_MULT: ns2tick_mult = pwdata;
					ADDR_MIN_WAKE:     min_wake = pwdata[15:0];
					default: ;
				endcase
			end
			// check the outgoing word before queueing the incoming one
			if (out_valid && out_ready) begin
				if (due_words.size() == 0) begin
					$display("%0t: unexpected word now_ns=%h status=%0d reload=%0d",
						$time, now_ns, status, reload_value);
					mismatches++;
				end else begin
					want = due_words.pop_front();
					if (now_ns !== want.now) begin
						$display("%0t: now_ns expected %h got %h", $time, want.now, now_ns);
						mismatches++;
					end
					if (status !== want.status) begin
						$display("%0t: status expected %0d got %0d", $time, want.status, status);
						mismatches++;
					end
					if (reload_value !== want.reload) begin
						$display("%0t: reload_value expected %0d got %0d", $time, want.reload,
							reload_value);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) due_words.push_back(advance_clock(mode, cycle_count,
				deadline_ns));
			open_words = due_words.size();
		end
	end

endmodule

[test/tb_tsc_monotonic_clock_and_wakeup.sv]
// Top of the monotonic clock testbench: clock, reset, register writes, input words and
// receiver stalls. Depends on tsc_pkg, the block under test and tsc_clock_monitor.
`timescale 1ns / 100ps

module tb_tsc_monotonic_clock_and_wakeup;
	import tsc_pkg::*;
	import tsc_tb_pkg::*;

	// Cycles with no word moving on either channel before the run is called hung.
	// The slowest legit quiet stretch is the long receiver hold plus one latency.
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD   = 400;
	localparam int SETTLE      = 24;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire  [31:0] prdata;
	wire         pready;
	logic        in_valid = 1'b0;
	wire         in_ready;
	logic [1:0]  mode = MODE_START;
	logic [63:0] cycle_count = '0;
	logic [63:0] deadline_ns = '0;
	wire         out_valid;
	logic        out_ready = 1'b0;
	wire  [63:0] now_ns;
	wire  [1:0]  status;
	wire  [15:0] reload_value;

	int          mismatches;
	int          open_words;

	int          items_sent = 0;
	int          words_taken = 0;
	logic [63:0] seen_now = '0;    // now_ns of the last word taken
	logic [63:0] sent_count = '0;  // cycle_count of the last word sent
	logic        hold_req = 1'b0;
	logic        tx_calm = 1'b0;
	logic        rx_calm = 1'b0;
	int          rx_wait = 0;
	int          quiet = 0;

	always #5 clk = ~clk;

	tsc_monotonic_clock_and_wakeup dut (.*);

	tsc_clock_monitor monitor (.*);

	// Mostly no gap, some short ones, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Spread deadlines around the current time so every status shows up:
	// behind, equal, a few ticks out, far out, or anywhere at all.
	function automatic logic [63:0] pick_deadline(input logic [63:0] base);
		case ($urandom_range(0, 4))
			0: return base - $urandom_range(1, 1000);
			1: return base;
			2: return base + (rand64() >> $urandom_range(0, 63));
			3: return base + $urandom_range(0, 100000);
			default: return rand64();
		endcase
	endfunction

	// Receiver: count taken words, stall at random, or hold off for a long
	// stretch when asked. Reset keeps ready low.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			words_taken <= words_taken + 1;
			seen_now <= now_ns;
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_req) begin
			out_ready <= 1'b0;
			rx_wait <= LONG_HOLD;
		end else if (rx_wait != 0) begin
			out_ready <= 1'b0;
			rx_wait <= rx_wait - 1;
		end else begin
			out_ready <= 1'b1;
			if (!rx_calm) rx_wait <= pick_gap();
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet <= 0;
			end else begin
				quiet <= quiet + 1;
			end
			if (quiet >= QUIET_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Offer one word and hold it until taken. Valid stays high on return so a
	// back-to-back word can follow in the same step without a low blip.
	task automatic send_word(input logic [1:0] m, input logic [63:0] cnt, input logic [63:0] dl);
		int gap;
		gap = tx_calm ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		cycle_count <= cnt;
		deadline_ns <= dl;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		sent_count = cnt;
	endtask

	// Drop valid and wait until every word sent has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (words_taken != items_sent) @(posedge clk);
	endtask

	task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Registers change only with the block idle.
	task automatic set_regs(input logic [31:0] c2ns, input logic [31:0] ns2tick,
			input logic [15:0] minw);
		drain();
		reg_write(ADDR_C2NS_MULT, c2ns);
		reg_write(ADDR_NS2TICK_MULT, ns2tick);
		reg_write(ADDR_MIN_WAKE, {16'd0, minw});
	endtask

	task automatic send_noise();
		send_word(2'($urandom_range(0, 3)), rand64(), rand64());
	endtask

	// Well-formed use: read (or restart) the clock, learn the time from the
	// returned word, then ask for one to three wakeups near that time.
	task automatic wake_burst();
		logic [63:0] cnt;
		if ($urandom_range(0, 9) == 0) begin
			cnt = rand64();
		end else begin
			cnt = sent_count + $urandom_range(0, 5000);
		end
		send_word(($urandom_range(0, 4) == 0) ? MODE_START : MODE_READ, cnt, rand64());
		drain();
		repeat ($urandom_range(1, 3)) begin
			if ($urandom_range(0, 1) != 0) cnt = cnt + $urandom_range(0, 200);
			send_word(MODE_WAKE, cnt, pick_deadline(seen_now));
		end
	endtask

	task automatic run_until(input int target);
		while (items_sent < target) begin
			if ($urandom_range(0, 99) < 70) begin
				wake_burst();
			end else begin
				send_noise();
			end
		end
	endtask

	// Freeze the receiver and keep offering words back to back so the
	// output register fills and the block stops taking input.
	task automatic squeeze();
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		tx_calm = 1'b1;
		repeat (24) send_noise();
		tx_calm = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: 0.5 ns per cycle, about 1.19 ticks per microsecond.
		send_word(MODE_START, 64'd0, '1);
		send_word(MODE_READ, 64'd0, '1);            // zero delta
		send_word(MODE_WAKE, 64'd0, 64'd0);         // deadline equal to now
		send_word(MODE_WAKE, 64'd0, '1);            // huge tick count, clamp
		send_word(MODE_WAKE, 64'd0, 64'd20000);     // a few ticks above the minimum
		send_word(MODE_WAKE, 64'd0, 64'd10000);     // below the minimum
		send_word(MODE_READ, '1, 64'd0);            // largest delta
		send_word(MODE_WAKE, '1, 64'd0);            // deadline behind now
		send_word(MODE_READ, 64'd5, 64'd0);         // counter wrap
		send_word(2'd3, 64'd1000, '1);              // unused mode reads the clock
		send_word(MODE_START, '1, 64'd0);
		send_word(MODE_START, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		send_word(MODE_WAKE, 64'h5555_5555_5555_5555, '1);
		run_until(150);

		// All-ones registers: the tick clamp meets the largest minimum.
		set_regs('1, '1, '1);
		send_word(MODE_START, 64'd0, 64'd0);
		send_word(MODE_WAKE, 64'd0, '1);
		send_word(MODE_WAKE, 64'd0, 64'd65535);     // 65534 ticks, just short
		send_word(MODE_WAKE, 64'd0, 64'd65536);     // exactly the cap
		squeeze();
		run_until(260);

		// All-zero registers, with no idling on either side.
		set_regs('0, '0, '0);
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		send_word(MODE_WAKE, '1, '1);               // zero ticks, zero minimum
		send_word(MODE_START, '1, 64'd0);
		run_until(330);
		tx_calm = 1'b0;
		rx_calm = 1'b0;

		set_regs($urandom, $urandom_range(1, 32'h0100_0000), 16'($urandom_range(0, 300)));
		run_until(420);
		set_regs($urandom, $urandom, 16'($urandom));
		run_until(510);
		set_regs($urandom_range(1, 32'h8000_0000), $urandom_range(32'h0010_0000, 32'h0400_0000),
			16'd1);
		squeeze();
		run_until(600);

		drain();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && open_words == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
